// ----- src/pnlf_pkg.sv -----
package pnlf_pkg;

	// Field widths fixed by the list format
	localparam int IDX_W      = 12;
	localparam int NBR_W      = 13;
	localparam int SLOT_W     = 13;
	localparam int LEN_W      = 24;
	localparam int SQ_W       = 2 * LEN_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_BEAD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_PROBE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAD_COUNT   = 2'd3;

	localparam logic [LEN_W-1:0] BOX_LENGTH_RST = 24'd4096;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = 2;

	typedef struct packed {
		logic [LEN_W-1:0] box_length;
		logic [LEN_W-1:0] cutoff_bead;
		logic [LEN_W-1:0] cutoff_probe;
		logic [NBR_W-1:0] bead_count;
	} pnlf_cfg_t;

	// Pair bookkeeping that rides along the front pipeline
	typedef struct packed {
		logic             row_start;
		logic             self_keep;
		logic [NBR_W-1:0] neighbor_index;
		logic [IDX_W-1:0] row_probe;
	} pnlf_tag_t;

	// One classified pair, handed from front to back
	typedef struct packed {
		pnlf_tag_t       tag;
		logic            over;
		logic [SQ_W-1:0] sq_x;
		logic [SQ_W-1:0] sq_y;
		logic [SQ_W-1:0] sq_z;
		logic [SQ_W-1:0] cut_sq;
	} pnlf_entry_t;

endpackage

// ----- src/pnlf_cand_if.sv -----
interface pnlf_cand_if #(parameter int COORD_BITS = 24);
	import pnlf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  row_start;
	logic                  cand_is_probe;
	logic [IDX_W-1:0]      ref_index;
	logic [IDX_W-1:0]      cand_index;
	logic [COORD_BITS-1:0] ref_x;
	logic [COORD_BITS-1:0] ref_y;
	logic [COORD_BITS-1:0] ref_z;
	logic [COORD_BITS-1:0] cand_x;
	logic [COORD_BITS-1:0] cand_y;
	logic [COORD_BITS-1:0] cand_z;

	modport source (
		output valid, row_start, cand_is_probe, ref_index, cand_index,
		output ref_x, ref_y, ref_z, cand_x, cand_y, cand_z,
		input  ready
	);

	modport sink (
		input  valid, row_start, cand_is_probe, ref_index, cand_index,
		input  ref_x, ref_y, ref_z, cand_x, cand_y, cand_z,
		output ready
	);

endinterface

// ----- src/pnlf_nbr_if.sv -----
interface pnlf_nbr_if;
	import pnlf_pkg::*;

	logic              valid;
	logic              ready;
	logic [NBR_W-1:0]  neighbor_index;
	logic [SLOT_W-1:0] list_slot;
	logic [IDX_W-1:0]  row_probe;

	modport source (
		output valid, neighbor_index, list_slot, row_probe,
		input  ready
	);

	modport sink (
		input  valid, neighbor_index, list_slot, row_probe,
		output ready
	);

endinterface

// ----- src/pnlf_front.sv -----
module pnlf_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pnlf_pkg::pnlf_cfg_t   cfg,
	pnlf_cand_if.sink             cand,
	input  logic                  q_full,
	output logic                  q_push,
	output pnlf_pkg::pnlf_entry_t q_entry
);
	import pnlf_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int WW = ((COORD_BITS > LEN_W) ? COORD_BITS : LEN_W) + 3;

	// Wrap one axis difference once by the box and return its magnitude
	function automatic logic [WW-1:0] wrap_abs(input logic signed [DW-1:0] d,
			input logic [LEN_W-1:0] len);
		logic signed [WW-1:0] dw;
		logic signed [WW-1:0] lw;
		logic signed [WW-1:0] dbl;
		logic signed [WW-1:0] r;
		dw  = WW'(d);
		lw  = signed'(WW'(len));
		dbl = dw <<< 1;
		r   = dw;
		if (dbl >= lw) begin
			r = dw - lw;
		end else if (dbl <= -lw) begin
			r = dw + lw;
		end
		return r[WW-1] ? WW'(-r) : WW'(r);
	endfunction

	logic                   v_s1, v_s2, v_s3;
	logic                   en1, en2, en3;
	logic signed [DW-1:0]   dx_s1, dy_s1, dz_s1;
	logic [LEN_W-1:0]       cut_s1, cut_s2;
	pnlf_tag_t              tag_s1, tag_s2;
	logic [LEN_W-1:0]       ax_s2, ay_s2, az_s2;
	logic                   over_s2;
	pnlf_entry_t            entry_s3;

	logic signed [DW-1:0]   dx_in, dy_in, dz_in;
	logic [WW-1:0]          ax, ay, az;
	pnlf_tag_t              tag_in;

	// Stage enables: a stage moves when it is empty or the next one moves
	assign en3        = !v_s3 || !q_full;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign cand.ready = en1;
	assign q_push     = v_s3 && !q_full;
	assign q_entry    = entry_s3;

	// Raw axis differences, candidate minus reference
	assign dx_in = $signed({1'b0, cand.cand_x}) - $signed({1'b0, cand.ref_x});
	assign dy_in = $signed({1'b0, cand.cand_y}) - $signed({1'b0, cand.ref_y});
	assign dz_in = $signed({1'b0, cand.cand_z}) - $signed({1'b0, cand.ref_z});

	// Classify the pair and form its output index
	always_comb begin
		tag_in.row_start      = cand.row_start;
		tag_in.self_keep      = cand.cand_is_probe && (cand.cand_index == cand.ref_index);
		tag_in.neighbor_index = cand.cand_is_probe ?
			NBR_W'(cand.cand_index) + cfg.bead_count : NBR_W'(cand.cand_index);
		tag_in.row_probe      = cand.ref_index;
	end

	// Minimum image wrap and per-axis cutoff test
	assign ax = wrap_abs(dx_s1, cfg.box_length);
	assign ay = wrap_abs(dy_s1, cfg.box_length);
	assign az = wrap_abs(dz_s1, cfg.box_length);

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cand.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1  <= dx_in;
			dy_s1  <= dy_in;
			dz_s1  <= dz_in;
			cut_s1 <= cand.cand_is_probe ? cfg.cutoff_probe : cfg.cutoff_bead;
			tag_s1 <= tag_in;
		end
		if (en2) begin
			ax_s2   <= ax[LEN_W-1:0];
			ay_s2   <= ay[LEN_W-1:0];
			az_s2   <= az[LEN_W-1:0];
			over_s2 <= (ax > WW'(cut_s1)) || (ay > WW'(cut_s1)) || (az > WW'(cut_s1));
			cut_s2  <= cut_s1;
			tag_s2  <= tag_s1;
		end
		if (en3) begin
			entry_s3.tag    <= tag_s2;
			entry_s3.over   <= over_s2;
			entry_s3.sq_x   <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
			entry_s3.sq_y   <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
			entry_s3.sq_z   <= SQ_W'(az_s2) * SQ_W'(az_s2);
			entry_s3.cut_sq <= SQ_W'(cut_s2) * SQ_W'(cut_s2);
		end
	end

	// A stall at the input only comes from a full pipeline behind a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cand.ready |-> (v_s1 && v_s2 && v_s3 && q_full))
		else $error("front stalled with room left");

endmodule

// ----- src/pnlf_queue.sv -----
module pnlf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pnlf_pkg::pnlf_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output pnlf_pkg::pnlf_entry_t head
);
	import pnlf_pkg::*;

	pnlf_entry_t       slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full       = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	// Empty queue has its pointers together
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers apart while empty");

endmodule

// ----- src/pnlf_back.sv -----
module pnlf_back #(
	parameter int MAX_PARTICLES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  pnlf_pkg::pnlf_entry_t head,
	output logic                  pop,
	pnlf_nbr_if.source            nbr
);
	import pnlf_pkg::*;

	localparam int SLOT_WRAP = (2 * MAX_PARTICLES < (1 << SLOT_W)) ?
		2 * MAX_PARTICLES : (1 << SLOT_W);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_WRAP - 1);

	logic              out_valid_q;
	logic [NBR_W-1:0]  nbr_index_q;
	logic [SLOT_W-1:0] list_slot_q;
	logic [IDX_W-1:0]  row_probe_q;
	logic [SLOT_W-1:0] slot_q;

	logic [SUM_W-1:0]  dist_sq;
	logic              keep;
	logic [SLOT_W-1:0] slot_base;
	logic [SLOT_W-1:0] slot_next;

	// Final distance test
	assign dist_sq = SUM_W'(head.sq_x) + SUM_W'(head.sq_y) + SUM_W'(head.sq_z);
	assign keep    = head.tag.self_keep ||
		(!head.over && (dist_sq < SUM_W'(head.cut_sq)));

	// Slot numbering restarts at row start and wraps at the list limit
	assign slot_base = head.tag.row_start ? '0 : slot_q;
	assign slot_next = (slot_base == SLOT_LAST) ? '0 : slot_base + 1'b1;

	assign pop = head_valid && (!out_valid_q || nbr.ready);

	assign nbr.valid          = out_valid_q;
	assign nbr.neighbor_index = nbr_index_q;
	assign nbr.list_slot      = list_slot_q;
	assign nbr.row_probe      = row_probe_q;

	// Hold result until transfer, track the slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			slot_q      <= '0;
		end else if (pop) begin
			out_valid_q <= keep;
			slot_q      <= keep ? slot_next : slot_base;
		end else if (nbr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (pop && keep) begin
			nbr_index_q <= head.tag.neighbor_index;
			list_slot_q <= slot_base;
			row_probe_q <= head.tag.row_probe;
		end
	end

	a_row_first_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && keep && head.tag.row_start) |=> (nbr.valid && (nbr.list_slot == '0)))
		else $error("first neighbor of a row not in slot zero");

	a_drop_holds_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !keep) |=> (slot_q == $past(slot_base)))
		else $error("dropped pair moved the slot counter");

	a_self_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.tag.self_keep) |=> nbr.valid)
		else $error("self pair not emitted");

endmodule

// ----- src/periodic_neighbor_list_filter.sv -----
// Channel  Dir  Payload                                              Transfer
// cand     in   row_start cand_is_probe ref/cand index, ref/cand xyz  valid && ready
// nbr      out  neighbor_index list_slot row_probe                   valid && ready
// cfg      in   cfg_index cfg_data                                   cfg_we
//
// One pair per cycle sustained until a held nbr fills the queue and all front stages;
// each pair passes every front stage and the queue before the back test loads nbr.
// Reset restores box length 1.0, zero cutoffs, zero bead count and slot zero.
// The four-entry queue lets the front keep taking pairs while nbr is held;
// cand.ready drops only once the queue and all front stages are full.
module periodic_neighbor_list_filter #(
	parameter int MAX_PARTICLES = 4096,
	parameter int COORD_BITS    = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pnlf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pnlf_pkg::CFG_DATA_W-1:0]     cfg_data,
	pnlf_cand_if.sink                           cand,
	pnlf_nbr_if.source                          nbr
);
	import pnlf_pkg::*;

	pnlf_cfg_t   cfg_q;
	logic        q_push, q_full, q_pop, q_head_valid;
	pnlf_entry_t q_entry, q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_length   <= BOX_LENGTH_RST;
			cfg_q.cutoff_bead  <= '0;
			cfg_q.cutoff_probe <= '0;
			cfg_q.bead_count   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOX_LENGTH:   cfg_q.box_length   <= cfg_data;
				CFG_CUTOFF_BEAD:  cfg_q.cutoff_bead  <= cfg_data;
				CFG_CUTOFF_PROBE: cfg_q.cutoff_probe <= cfg_data;
				CFG_BEAD_COUNT:   cfg_q.bead_count   <= cfg_data[NBR_W-1:0];
				default: ;
			endcase
		end
	end

	pnlf_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cand    (cand),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	pnlf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	pnlf_back #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.nbr        (nbr)
	);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import pnlf_pkg::*;

	localparam int COORD_W      = 24;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 1_500_000;

	typedef struct {
		bit               row_start;
		bit               is_probe;
		bit [IDX_W-1:0]   ref_idx;
		bit [IDX_W-1:0]   cand_idx;
		bit [COORD_W-1:0] rx, ry, rz;
		bit [COORD_W-1:0] cx, cy, cz;
	} pair_t;

	typedef struct {
		logic [NBR_W-1:0]  neighbor_index;
		logic [SLOT_W-1:0] list_slot;
		logic [IDX_W-1:0]  row_probe;
	} nbr_t;

	// Predicts kept pairs and holds the neighbor entries still to come
	class neighbor_scoreboard;
		bit [LEN_W-1:0]  box_len  = BOX_LENGTH_RST;
		bit [LEN_W-1:0]  cut_bead;
		bit [LEN_W-1:0]  cut_probe;
		bit [NBR_W-1:0]  bead_cnt;
		bit [SLOT_W-1:0] slot;
		nbr_t            pending_nbrs[$];
		int              errors;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_BOX_LENGTH:   box_len   = val;
				CFG_CUTOFF_BEAD:  cut_bead  = val;
				CFG_CUTOFF_PROBE: cut_probe = val;
				CFG_BEAD_COUNT:   bead_cnt  = val[NBR_W-1:0];
				default: ;
			endcase
		endfunction

		// Minimum-image magnitude of one axis, a single wrap only
		function longint unsigned wrap_mag(bit [COORD_W-1:0] c, bit [COORD_W-1:0] r);
			longint d;
			longint len;
			d   = longint'(c) - longint'(r);
			len = longint'(box_len);
			if (2 * d >= len)
				d = d - len;
			else if (2 * d <= -len)
				d = d + len;
			return (d < 0) ? longint'(-d) : d;
		endfunction

		function void note_pair(pair_t p);
			longint unsigned cut, ax, ay, az, d2;
			bit              keep;
			nbr_t            entry;
			cut = 64'(p.is_probe ? cut_probe : cut_bead);
			if (p.row_start)
				slot = '0;
			if (p.is_probe && p.cand_idx == p.ref_idx) begin
				keep = 1'b1;
			end else begin
				ax = wrap_mag(p.cx, p.rx);
				ay = wrap_mag(p.cy, p.ry);
				az = wrap_mag(p.cz, p.rz);
				if (ax > cut || ay > cut || az > cut) begin
					keep = 1'b0;
				end else begin
					d2   = ax * ax + ay * ay + az * az;
					keep = d2 < cut * cut;
				end
			end
			if (!keep)
				return;
			entry.neighbor_index = p.is_probe ? NBR_W'({1'b0, p.cand_idx} + bead_cnt)
				: {1'b0, p.cand_idx};
			entry.list_slot = slot;
			entry.row_probe = p.ref_idx;
			pending_nbrs = {pending_nbrs, entry};
			slot = slot + 1'b1;
		endfunction

		function void check_result(nbr_t got);
			nbr_t want;
			if (pending_nbrs.size() == 0) begin
				$error("unexpected neighbor transfer: neighbor_index %0d list_slot %0d row_probe %0d",
					got.neighbor_index, got.list_slot, got.row_probe);
				errors++;
				return;
			end
			want = pending_nbrs.pop_front();
			if (got.neighbor_index !== want.neighbor_index) begin
				$error("neighbor_index: expected %0d, actual %0d", want.neighbor_index,
					got.neighbor_index);
				errors++;
			end
			if (got.list_slot !== want.list_slot) begin
				$error("list_slot: expected %0d, actual %0d", want.list_slot, got.list_slot);
				errors++;
			end
			if (got.row_probe !== want.row_probe) begin
				$error("row_probe: expected %0d, actual %0d", want.row_probe, got.row_probe);
				errors++;
			end
		endfunction

		function int pending();
			return pending_nbrs.size();
		endfunction

		function int failures();
			if (pending_nbrs.size() != 0)
				$error("%0d neighbor entries never arrived", pending_nbrs.size());
			return errors + pending_nbrs.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pnlf_cand_if #(.COORD_BITS(COORD_W)) cand_ch ();
	pnlf_nbr_if                          nbr_ch ();

	neighbor_scoreboard sb = new();

	bit               idle_on;
	int               hold_left;
	int               cycle_cnt;
	bit               row_fresh = 1'b1;
	bit [IDX_W-1:0]   row_ref_idx;
	bit [COORD_W-1:0] row_x, row_y, row_z;

	periodic_neighbor_list_filter #(
		.MAX_PARTICLES(4096),
		.COORD_BITS   (COORD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cand     (cand_ch),
		.nbr      (nbr_ch)
	);

	always #5 clk = ~clk;

	initial begin
		cand_ch.valid         = 1'b0;
		cand_ch.row_start     = 1'b0;
		cand_ch.cand_is_probe = 1'b0;
		cand_ch.ref_index     = '0;
		cand_ch.cand_index    = '0;
		cand_ch.ref_x         = '0;
		cand_ch.ref_y         = '0;
		cand_ch.ref_z         = '0;
		cand_ch.cand_x        = '0;
		cand_ch.cand_y        = '0;
		cand_ch.cand_z        = '0;
		nbr_ch.ready          = 1'b0;
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			nbr_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			nbr_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			hold_left    <= $urandom_range(0, 18);
			nbr_ch.ready <= 1'b0;
		end else begin
			nbr_ch.ready <= 1'b1;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		nbr_t got;
		if (arst_n && nbr_ch.valid && nbr_ch.ready) begin
			got.neighbor_index = nbr_ch.neighbor_index;
			got.list_slot      = nbr_ch.list_slot;
			got.row_probe      = nbr_ch.row_probe;
			sb.check_result(got);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic pair_t mk(int rs, int pr, int ri, int ci,
		int rx, int ry, int rz, int cx, int cy, int cz);
		pair_t p;
		p.row_start = rs[0];
		p.is_probe  = pr[0];
		p.ref_idx   = ri[IDX_W-1:0];
		p.cand_idx  = ci[IDX_W-1:0];
		p.rx = rx[COORD_W-1:0];
		p.ry = ry[COORD_W-1:0];
		p.rz = rz[COORD_W-1:0];
		p.cx = cx[COORD_W-1:0];
		p.cy = cy[COORD_W-1:0];
		p.cz = cz[COORD_W-1:0];
		return p;
	endfunction

	// Candidate coordinate within span of the reference, folded into the box
	function automatic bit [COORD_W-1:0] near_coord(bit [COORD_W-1:0] base, longint span);
		longint off, c, len;
		off = longint'($urandom_range(0, 32'(2 * span))) - span;
		c   = longint'(base) + off;
		len = longint'(sb.box_len);
		if (len > 0) begin
			c = c % len;
			if (c < 0)
				c = c + len;
		end
		return c[COORD_W-1:0];
	endfunction

	function automatic bit [COORD_W-1:0] box_coord();
		if (sb.box_len == 0)
			return COORD_W'($urandom);
		return COORD_W'($urandom_range(0, sb.box_len - 1));
	endfunction

	// Mostly well-formed rows around one reference probe, some noise
	function automatic pair_t next_random_pair();
		pair_t           p;
		int              pick;
		bit              rs;
		longint unsigned cut;
		longint          span;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			p = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
			return p;
		end
		rs = 1'b0;
		if (row_fresh || $urandom_range(0, 9) == 0) begin
			row_fresh   = 1'b0;
			rs          = 1'b1;
			row_ref_idx = IDX_W'($urandom);
			row_x       = box_coord();
			row_y       = box_coord();
			row_z       = box_coord();
		end
		p.row_start = rs;
		p.ref_idx   = row_ref_idx;
		p.rx        = row_x;
		p.ry        = row_y;
		p.rz        = row_z;
		if (pick < 20) begin
			p.is_probe = 1'b1;
			p.cand_idx = row_ref_idx;
			p.cx = COORD_W'($urandom);
			p.cy = COORD_W'($urandom);
			p.cz = COORD_W'($urandom);
			return p;
		end
		p.is_probe = 1'($urandom);
		p.cand_idx = IDX_W'($urandom);
		cut  = 64'(p.is_probe ? sb.cut_probe : sb.cut_bead);
		span = cut - cut / 4 + 1;
		if ($urandom_range(0, 3) == 0)
			span = cut + cut / 8 + 2;
		p.cx = near_coord(p.rx, span);
		p.cy = near_coord(p.ry, span);
		p.cz = near_coord(p.rz, span);
		return p;
	endfunction

	task automatic send_pair(input pair_t p);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			cand_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cand_ch.valid         <= 1'b1;
		cand_ch.row_start     <= p.row_start;
		cand_ch.cand_is_probe <= p.is_probe;
		cand_ch.ref_index     <= p.ref_idx;
		cand_ch.cand_index    <= p.cand_idx;
		cand_ch.ref_x         <= p.rx;
		cand_ch.ref_y         <= p.ry;
		cand_ch.ref_z         <= p.rz;
		cand_ch.cand_x        <= p.cx;
		cand_ch.cand_y        <= p.cy;
		cand_ch.cand_z        <= p.cz;
		do
			@(posedge clk);
		while (!cand_ch.ready);
		sb.note_pair(p);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_pair(next_random_pair());
	endtask

	// Drop valid, then wait for every expected entry and the pipeline tail
	task automatic end_phase();
		@(negedge clk);
		cand_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(input int box, input int cb, input int cp, input int bc);
		write_reg(CFG_BOX_LENGTH, box[CFG_DATA_W-1:0]);
		write_reg(CFG_CUTOFF_BEAD, cb[CFG_DATA_W-1:0]);
		write_reg(CFG_CUTOFF_PROBE, cp[CFG_DATA_W-1:0]);
		write_reg(CFG_BEAD_COUNT, bc[CFG_DATA_W-1:0]);
		@(negedge clk);
		cfg_we    <= 1'b0;
		row_fresh = 1'b1;
	endtask

	task automatic random_config();
		int box;
		box = $urandom_range(1, 32'hFFFFFF);
		set_config(box, $urandom_range(0, box / 3), $urandom_range(0, box / 3),
			$urandom_range(0, 4096));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		// Reset settings: zero cutoffs keep only self pairs
		run_random(20);
		end_phase();

		// Directed pairs, box 16.0, bead cutoff 2.0, probe cutoff 3.0
		set_config(65536, 8192, 12288, 100);
		send_pair(mk(1, 0, 7, 0, 1000, 1000, 1000, 1000, 1000, 1000));
		send_pair(mk(0, 0, 7, 1, 1000, 1000, 1000, 9192, 1000, 1000));
		send_pair(mk(0, 0, 7, 2, 1000, 1000, 1000, 9191, 1000, 1000));
		send_pair(mk(0, 0, 7, 3, 1000, 1000, 1000, 6000, 6000, 6000));
		send_pair(mk(0, 1, 7, 7, 1000, 1000, 1000, 60000, 60000, 60000));
		send_pair(mk(0, 1, 7, 4095, 1000, 1000, 1000, 13287, 1000, 1000));
		send_pair(mk(0, 1, 7, 8, 1000, 1000, 1000, 9192, 1000, 1000));
		// Wrap down on every axis, wrap up, exactly plus and minus half a box
		send_pair(mk(1, 0, 4095, 4095, 0, 0, 0, 65535, 65535, 65535));
		send_pair(mk(0, 0, 4095, 10, 65535, 0, 0, 0, 1, 0));
		send_pair(mk(0, 0, 4095, 11, 0, 0, 0, 32768, 0, 0));
		send_pair(mk(0, 0, 4095, 12, 32768, 0, 0, 0, 0, 0));
		// Coordinates outside the box get one wrap only
		send_pair(mk(0, 0, 4095, 13, 0, 0, 0, 32'hFFFFFF, 0, 0));
		send_pair(mk(0, 0, 4095, 14, 32'hFFFFF0, 32'hFFFFFF, 32'hFFFFFF,
			32'hFFFFFF, 32'hFFFFF0, 32'hFFFFFF));
		send_pair(mk(1, 1, 0, 0, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 0, 0, 0));
		send_pair(mk(0, 0, 0, 4095, 100, 100, 100, 200, 100, 100));
		// Row restart with the same reference
		send_pair(mk(1, 0, 0, 5, 100, 100, 100, 100, 100, 100));
		end_phase();

		// Probe index overflow past 13 bits
		set_config(65536, 8192, 12288, 8191);
		send_pair(mk(1, 1, 3, 4095, 500, 500, 500, 500, 500, 500));
		send_pair(mk(0, 1, 3, 3, 500, 500, 500, 9000, 9000, 9000));
		end_phase();

		// Zero box: no wrap at all
		set_config(0, 8192, 8192, 4096);
		send_pair(mk(1, 0, 1, 1, 0, 0, 0, 32'hFFFFFF, 0, 0));
		send_pair(mk(0, 0, 1, 2, 10, 10, 10, 20, 20, 20));
		send_pair(mk(0, 1, 1, 2, 32'hFFFFFF, 0, 0, 0, 0, 0));
		end_phase();

		// Random phases across fixed extremes and random settings
		set_config(32'hFFFFFF, 32'hFFFFFF, 0, 4096);
		run_random(100);
		end_phase();
		set_config(1, 1, 4096, 0);
		run_random(100);
		end_phase();
		set_config(0, 3000, 300000, 8191);
		run_random(100);
		end_phase();
		set_config(4096, 4096, 2048, 1);
		run_random(100);
		end_phase();
		repeat (3) begin
			random_config();
			run_random(100);
			end_phase();
		end

		// No idling from here on
		idle_on = 1'b0;
		random_config();
		run_random(60);
		end_phase();

		if (sb.failures() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
